// ----- hdl/shortest_common_supersequence_assert.svh -----
// Assertion macros for the shortest common supersequence block.
`ifndef SHORTEST_COMMON_SUPERSEQUENCE_ASSERT_SVH
`define SHORTEST_COMMON_SUPERSEQUENCE_ASSERT_SVH
// Checks that an implication holds at every clock edge outside reset.
`define SCS_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define SCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ----- hdl/scs_pkg.sv -----
// Package with the types and constants of the shortest common supersequence block.
`default_nettype none
package scs_pkg;
    localparam int unsigned OP_W  = 2;
    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN           = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FRD    = 9'b000000010,
        S_FWAIT  = 9'b000000100,
        S_FCALC  = 9'b000001000,
        S_TRD    = 9'b000010000,
        S_TWAIT  = 9'b000100000,
        S_TDEC   = 9'b001000000,
        S_ORD    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;
endpackage
`default_nettype wire

// ----- hdl/shortest_common_supersequence.sv -----
// Top level of the shortest common supersequence block.
`default_nettype none
// Append requests (operation 0 or 1) load a byte into the first or second
// string; appends past MAX_LEN bytes are dropped and raise the overflowed
// flag at once, which is cleared when a run is done. A run request (operation 2)
// fills a longest-common-subsequence table held in one synchronous memory;
// each cell needs three reads (diagonal, up and left) through the single
// read port, each read taking an address state and a wait state, followed by
// a write state. It then traces the table back with two reads and a decision
// per answer byte, and finally streams the answer front to back from an
// answer memory, one byte at a time, each waiting for the consumer to be
// ready. The last byte carries is_last; two empty strings give one result
// with is_empty set, valid in the cycle after the run request. New requests
// are held off until a run is done.
module shortest_common_supersequence #(
    parameter int unsigned MAX_LEN = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_operation,
    input  wire logic [7:0]          i_symbol,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [7:0]               o_symbol_res,
    output logic                     o_is_last,
    output logic                     o_is_empty,
    output logic                     o_overflowed
);
    import scs_pkg::*;
    `include "shortest_common_supersequence_assert.svh"

    localparam int unsigned LW   = $clog2(MAX_LEN + 1);
    localparam int unsigned IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned DIM  = MAX_LEN + 1;
    localparam int unsigned TD   = DIM * DIM;
    localparam int unsigned TAW  = $clog2(TD);
    localparam int unsigned AD   = 2 * MAX_LEN;
    localparam int unsigned AAW  = $clog2(AD + 1);
    localparam int unsigned AIW  = $clog2(AD);

    // Storage: strings, length table and answer buffer.
    logic [7:0]    r_first  [MAX_LEN];
    logic [7:0]    r_second [MAX_LEN];
    logic [LW-1:0] r_table  [TD];
    logic [7:0]    r_answer [AD];

    logic [LW-1:0] r_n1, r_n2;
    logic          r_ovf;
    t_state        r_state;
    logic [LW-1:0] r_r, r_c;
    logic [1:0]    r_ph;
    logic [LW-1:0] r_diag, r_up;
    logic [AAW-1:0] r_k, r_oi;
    logic          r_empty;

    // Memory read port.
    logic [TAW-1:0] w_raddr;
    logic [LW-1:0]  r_rdata;
    logic           w_we;
    logic [TAW-1:0] w_waddr;
    logic [LW-1:0]  w_wdata;
    logic [7:0]     r_a, r_b;
    logic [7:0]     r_ans_q;
    logic           r_ovalid;

    function automatic logic [TAW-1:0] addr(input logic [LW-1:0] r, input logic [LW-1:0] c);
        logic [TAW+LW-1:0] p;
        p = TAW'(r) * TAW'(DIM) + TAW'(c);
        return p[TAW-1:0];
    endfunction

    logic [LW-1:0] w_rm1, w_cm1;
    assign w_rm1 = r_r - LW'(1);
    assign w_cm1 = r_c - LW'(1);

    always_comb begin
        w_raddr = addr(w_rm1, w_cm1);
        if (r_state == S_TRD) begin
            w_raddr = (r_ph == 2'd0) ? addr(r_r, w_cm1) : addr(w_rm1, r_c);
        end else begin
            unique case (r_ph)
                2'd0:    w_raddr = addr(w_rm1, w_cm1);
                2'd1:    w_raddr = addr(w_rm1, r_c);
                default: w_raddr = addr(r_r, w_cm1);
            endcase
        end
    end

    logic w_match;
    assign w_match = (r_a == r_b);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = addr(r_r, r_c);
        w_wdata = '0;
        if (r_state == S_FCALC) begin
            w_we = 1'b1;
            if (r_r == '0 || r_c == '0) w_wdata = '0;
            else if (w_match) w_wdata = r_diag + LW'(1);
            else w_wdata = (r_up > r_rdata) ? r_up : r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_table[w_raddr];
        if (w_we) r_table[w_waddr] <= w_wdata;
        r_a <= r_first[w_rm1[IW-1:0]];
        r_b <= r_second[w_cm1[IW-1:0]];
        r_ans_q <= r_answer[AIW'(r_k - r_oi - AAW'(1))];
        if (i_valid && o_ready && i_operation == OP_APPEND_FIRST && r_n1 < LW'(MAX_LEN))
            r_first[r_n1[IW-1:0]] <= i_symbol;
        if (i_valid && o_ready && i_operation == OP_APPEND_SECOND && r_n2 < LW'(MAX_LEN))
            r_second[r_n2[IW-1:0]] <= i_symbol;
        if (r_state == S_TDEC)
            r_answer[r_k[AIW-1:0]] <= (r_r != '0 && (r_c == '0 || w_match ||
                !(r_diag > r_up))) ? r_a : r_b;
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n1     <= '0;
            r_n2     <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_ph     <= '0;
            r_k      <= '0;
            r_oi     <= '0;
            r_empty  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_operation)
                            OP_APPEND_FIRST: begin
                                if (r_n1 < LW'(MAX_LEN)) r_n1 <= r_n1 + LW'(1);
                                else r_ovf <= 1'b1;
                            end
                            OP_APPEND_SECOND: begin
                                if (r_n2 < LW'(MAX_LEN)) r_n2 <= r_n2 + LW'(1);
                                else r_ovf <= 1'b1;
                            end
                            OP_RUN: begin
                                r_k <= '0;
                                r_oi <= '0;
                                if (r_n1 == '0 && r_n2 == '0) begin
                                    r_empty  <= 1'b1;
                                    r_ovalid <= 1'b1;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_empty <= 1'b0;
                                    r_r  <= '0;
                                    r_c  <= '0;
                                    r_ph <= '0;
                                    r_state <= S_FRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // Three reads per cell: diagonal, up, then left.
                S_FRD: begin
                    r_ph <= r_ph + 2'd1;
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (r_ph == 2'd1) begin
                        r_diag <= r_rdata;
                        r_state <= S_FRD;
                    end else if (r_ph == 2'd2) begin
                        r_up <= r_rdata;
                        r_state <= S_FRD;
                    end else begin
                        r_state <= S_FCALC;
                    end
                end
                S_FCALC: begin
                    r_ph <= '0;
                    if (r_c == r_n2) begin
                        r_c <= '0;
                        if (r_r == r_n1) begin
                            r_c <= r_n2;
                            r_state <= S_TRD;
                        end else begin
                            r_r <= r_r + LW'(1);
                            r_state <= S_FRD;
                        end
                    end else begin
                        r_c <= r_c + LW'(1);
                        r_state <= S_FRD;
                    end
                end
                // Trace: read left, then up; r_diag holds left, r_up holds up.
                S_TRD: begin
                    if (r_r == '0 && r_c == '0) begin
                        r_state <= S_ORD;
                    end else begin
                        r_ph <= r_ph + 2'd1;
                        r_state <= S_TWAIT;
                    end
                end
                S_TWAIT: begin
                    if (r_ph == 2'd1) begin
                        r_diag <= r_rdata;
                        r_state <= S_TRD;
                    end else begin
                        r_up <= r_rdata;
                        r_state <= S_TDEC;
                    end
                end
                S_TDEC: begin
                    r_ph <= '0;
                    r_k <= r_k + AAW'(1);
                    if (r_r != '0 && r_c != '0 && w_match) begin
                        r_r <= w_rm1;
                        r_c <= w_cm1;
                    end else if (r_r != '0 && (r_c == '0 || !(r_diag > r_up))) begin
                        r_r <= w_rm1;
                    end else begin
                        r_c <= w_cm1;
                    end
                    r_state <= S_TRD;
                end
                S_ORD: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        if (r_empty || r_oi + AAW'(1) == r_k) begin
                            r_n1 <= '0;
                            r_n2 <= '0;
                            r_ovf <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_oi <= r_oi + AAW'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_symbol_res = r_empty ? 8'd0 : r_ans_q;
    assign o_is_last    = r_empty || (r_oi + AAW'(1) == r_k);
    assign o_is_empty   = r_empty;
    assign o_overflowed = r_ovf;

    `SCS_ASSERT_IMPL(a_valid_state, i_clk, i_rst_n, !o_valid || r_state == S_OUT, "valid outside output")
    `SCS_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, r_n1 <= LW'(MAX_LEN) && r_n2 <= LW'(MAX_LEN), "length past capacity")
    `SCS_ASSERT_NEXT(a_run_end, i_clk, i_rst_n, o_valid && i_ready && o_is_last, r_n1 == '0 && r_n2 == '0 && !r_ovf, "state not cleared after run")
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the shortest common supersequence block.
`default_nettype none
module tb;
    import scs_pkg::*;

    localparam int unsigned MAX_LEN = 32;
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] symbol_res;
        logic       is_last;
        logic       is_empty;
        logic       overflowed;
    } t_scs_byte;

    // One row of the directed stimulus. A row can carry the result that a
    // run request must give when that can be read off at a glance.
    typedef struct {
        logic [OP_W-1:0] op;
        logic [7:0]      sym;
        bit              typed;
        t_scs_byte       want;
    } t_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    logic [1:0]      i_operation = '0;
    logic [7:0]      i_symbol = '0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    logic [7:0]      o_symbol_res;
    logic            o_is_last;
    logic            o_is_empty;
    logic            o_overflowed;

    shortest_common_supersequence #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_symbol(i_symbol),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_symbol_res(o_symbol_res), .o_is_last(o_is_last),
        .o_is_empty(o_is_empty), .o_overflowed(o_overflowed)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the block's strings and flag.
    logic [7:0] first_str [MAX_LEN];
    logic [7:0] second_str [MAX_LEN];
    int unsigned first_cnt, second_cnt;
    bit          dropped_flag;

    t_scs_byte pending_bytes[$];
    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    bit        quiet_tail = 1'b0;
    bit        hold_off_req = 1'b0;

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("MISMATCH @%0d: %s", cycle_cnt, what);
    endtask

    // Builds the supersequence of the shadow strings and queues its bytes.
    task automatic predict_supersequence();
        int unsigned lcs [MAX_LEN+1][MAX_LEN+1];
        logic [7:0]  rev [$];
        int unsigned r, c, k;
        t_scs_byte   b;
        if (first_cnt == 0 && second_cnt == 0) begin
            b = '{symbol_res: 8'd0, is_last: 1'b1, is_empty: 1'b1,
                  overflowed: dropped_flag};
            pending_bytes = {pending_bytes, b};
        end else begin
            for (r = 0; r <= first_cnt; r++) begin
                for (c = 0; c <= second_cnt; c++) begin
                    if (r == 0 || c == 0)
                        lcs[r][c] = 0;
                    else if (first_str[r-1] == second_str[c-1])
                        lcs[r][c] = (lcs[r-1][c-1] + 1) & 6'h3f;
                    else
                        lcs[r][c] = (lcs[r-1][c] > lcs[r][c-1]) ?
                                    lcs[r-1][c] : lcs[r][c-1];
                end
            end
            r = first_cnt;
            c = second_cnt;
            while (r > 0 && c > 0) begin
                if (first_str[r-1] == second_str[c-1]) begin
                    rev = {rev, first_str[r-1]};
                    r--;
                    c--;
                end else if (lcs[r][c-1] > lcs[r-1][c]) begin
                    rev = {rev, second_str[c-1]};
                    c--;
                end else begin
                    rev = {rev, first_str[r-1]};
                    r--;
                end
            end
            while (r > 0) begin
                rev = {rev, first_str[r-1]};
                r--;
            end
            while (c > 0) begin
                rev = {rev, second_str[c-1]};
                c--;
            end
            for (k = 0; k < rev.size(); k++) begin
                b.symbol_res = rev[rev.size()-1-k];
                b.is_last    = (k + 1 == rev.size());
                b.is_empty   = 1'b0;
                b.overflowed = dropped_flag;
                pending_bytes = {pending_bytes, b};
            end
        end
        first_cnt = 0;
        second_cnt = 0;
        dropped_flag = 1'b0;
    endtask

    // Applies one accepted request to the shadow state.
    task automatic apply_request(input logic [1:0] op, input logic [7:0] sym);
        case (op)
            OP_APPEND_FIRST: begin
                if (first_cnt < MAX_LEN) begin
                    first_str[first_cnt] = sym;
                    first_cnt++;
                end else begin
                    dropped_flag = 1'b1;
                end
            end
            OP_APPEND_SECOND: begin
                if (second_cnt < MAX_LEN) begin
                    second_str[second_cnt] = sym;
                    second_cnt++;
                end else begin
                    dropped_flag = 1'b1;
                end
            end
            OP_RUN: predict_supersequence();
            default: ;
        endcase
    endtask

    // Offers one request with random gaps and waits for its acceptance.
    // Valid stays up after acceptance; the next request or a gap replaces it
    // in the same time step.
    task automatic send_request(input logic [1:0] op, input logic [7:0] sym);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_symbol <= sym;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_request(op, sym);
    endtask

    // Sends a directed row; a typed row also checks its expectation against the newest queued byte.
    task automatic send_row(input t_row row);
        if (row.typed && row.op == OP_RUN && pending_bytes.size() == 0 &&
                first_cnt == 0 && second_cnt == 0 && dropped_flag == row.want.overflowed)
            ;
        else if (row.typed)
            report_mismatch("directed row expectation disagrees with shadow state");
        send_request(row.op, row.sym);
        if (row.typed && pending_bytes.size() > 0 && pending_bytes[$] !== row.want)
            report_mismatch("directed expected result differs from predictor");
    endtask

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 17);
                i_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result checker: every accepted byte is compared with the oldest one due.
    always @(posedge i_clk) begin
        t_scs_byte due;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                due = pending_bytes.pop_front();
                if (!due.is_empty && o_symbol_res !== due.symbol_res)
                    report_mismatch($sformatf("symbol %0h, expected %0h",
                                              o_symbol_res, due.symbol_res));
                if (o_is_last !== due.is_last)
                    report_mismatch("is_last differs");
                if (o_is_empty !== due.is_empty)
                    report_mismatch("is_empty differs");
                if (o_overflowed !== due.overflowed)
                    report_mismatch("overflowed differs");
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed rows: empty runs, extreme symbols, reversed, one-sided and
    // disjoint strings, the ignored operation.
    t_row directed [] = '{
        '{OP_RUN,          8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
        '{OP_IGNORED,      8'hff, 1'b0, '0},
        '{OP_RUN,          8'hff, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
        '{OP_APPEND_FIRST, 8'h00, 1'b0, '0},
        '{OP_APPEND_FIRST, 8'hff, 1'b0, '0},
        '{OP_APPEND_SECOND,8'hff, 1'b0, '0},
        '{OP_APPEND_SECOND,8'h00, 1'b0, '0},
        '{OP_RUN,          8'h00, 1'b0, '0},
        '{OP_APPEND_FIRST, 8'h55, 1'b0, '0},
        '{OP_RUN,          8'h00, 1'b0, '0},
        '{OP_APPEND_SECOND,8'haa, 1'b0, '0},
        '{OP_RUN,          8'h00, 1'b0, '0},
        '{OP_APPEND_FIRST, 8'h12, 1'b0, '0},
        '{OP_APPEND_SECOND,8'h34, 1'b0, '0},
        '{OP_RUN,          8'h00, 1'b0, '0}
    };

    initial begin
        int i, j, n1, n2, alpha;
        for (i = 0; i < MAX_LEN; i++) begin
            first_str[i] = '0;
            second_str[i] = '0;
        end
        first_cnt = 0;
        second_cnt = 0;
        dropped_flag = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_row(directed[i]);

        // Both strings filled past capacity: the longest answer and overflow.
        for (i = 0; i < MAX_LEN + 2; i++) begin
            send_request(OP_APPEND_FIRST, 8'($urandom_range(0, 255)));
            send_request(OP_APPEND_SECOND, 8'($urandom_range(0, 255)));
        end
        send_request(OP_RUN, 8'h00);

        // Long receiver hold-off while requests keep coming.
        hold_off_req = 1'b1;
        for (i = 0; i < 6; i++) begin
            send_request(OP_APPEND_FIRST, 8'($urandom_range(0, 3)));
            send_request(OP_APPEND_SECOND, 8'($urandom_range(0, 3)));
            send_request(OP_RUN, 8'h00);
        end

        // Random runs, mostly short strings over small alphabets so that matches
        // are common, now and then past capacity; a few noise requests mixed in.
        for (j = 0; j < 10; j++) begin
            if (j == 8) quiet_tail = 1'b1;
            n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN + 1)
                                             : $urandom_range(0, 3);
            n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN + 1)
                                             : $urandom_range(0, 3);
            alpha = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 4);
            while (n1 > 0 || n2 > 0) begin
                if ($urandom_range(0, 15) == 0)
                    send_request(OP_IGNORED, 8'($urandom_range(0, 255)));
                if (n1 > 0 && (n2 == 0 || $urandom_range(0, 1))) begin
                    send_request(OP_APPEND_FIRST, 8'($urandom_range(0, alpha)));
                    n1--;
                end else begin
                    send_request(OP_APPEND_SECOND, 8'($urandom_range(0, alpha)));
                    n2--;
                end
            end
            send_request(OP_RUN, 8'($urandom_range(0, 255)));
        end
        i_valid <= 1'b0;

        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
